>>> sv/assert_macros.svh
// assertion helpers included by the rtl top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication that holds on the next clock edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/e2q_pkg.sv
package e2q_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;
    localparam int CORDIC_ITERS   = 32;
    // cordic datapath width: q32 with sign and growth headroom
    localparam int CW             = 36;
    // q30 trig value width: range [-2^30, 2^30]
    localparam int TW             = 32;
    localparam logic signed [CW-1:0] CORDIC_GAIN_INV = 36'sd2608131497;
    localparam logic signed [CW-1:0] ONE_Q32 = 36'sd4294967296;

    typedef struct packed {
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
    } e2q_in_t;

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } e2q_out_t;

    // cos and sin of the three half angles, q30
    typedef struct packed {
        logic signed [TW-1:0] cx;
        logic signed [TW-1:0] sx;
        logic signed [TW-1:0] cy;
        logic signed [TW-1:0] sy;
        logic signed [TW-1:0] cz;
        logic signed [TW-1:0] sz;
    } e2q_trig_t;

    // arctangent of 2^-i, 2^32 units per turn
    function automatic logic signed [CW-1:0] atan_entry(input int i);
        logic signed [CW-1:0] t;
        case (i)
            0: t = 36'sd536870912;
            1: t = 36'sd316933406;
            2: t = 36'sd167458907;
            3: t = 36'sd85004756;
            4: t = 36'sd42667331;
            5: t = 36'sd21354465;
            6: t = 36'sd10679838;
            7: t = 36'sd5340245;
            8: t = 36'sd2670163;
            9: t = 36'sd1335087;
            10: t = 36'sd667544;
            11: t = 36'sd333772;
            12: t = 36'sd166886;
            13: t = 36'sd83443;
            14: t = 36'sd41722;
            15: t = 36'sd20861;
            16: t = 36'sd10430;
            17: t = 36'sd5215;
            18: t = 36'sd2608;
            19: t = 36'sd1304;
            20: t = 36'sd652;
            21: t = 36'sd326;
            22: t = 36'sd163;
            23: t = 36'sd81;
            24: t = 36'sd41;
            25: t = 36'sd20;
            26: t = 36'sd10;
            27: t = 36'sd5;
            28: t = 36'sd3;
            29: t = 36'sd1;
            30: t = 36'sd1;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

>>> sv/e2q_cordic.sv
// pipelined rotation-mode cordic, one micro-rotation per stage
module e2q_cordic
    import e2q_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] in_angle,
    output logic                 out_valid,
    output logic signed [TW-1:0] out_cos,
    output logic signed [TW-1:0] out_sin
);

    logic                 v_reg [CORDIC_ITERS+1];
    logic signed [CW-1:0] x_reg [CORDIC_ITERS+1];
    logic signed [CW-1:0] y_reg [CORDIC_ITERS+1];
    logic signed [CW-1:0] z_reg [CORDIC_ITERS+1];
    logic signed [CW-1:0] xc;
    logic signed [CW-1:0] yc;
    logic signed [TW-1:0] cos_next;
    logic signed [TW-1:0] sin_next;
    logic                 vo_reg;
    logic signed [TW-1:0] cos_reg;
    logic signed [TW-1:0] sin_reg;

    // stage zero: load start vector
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= CORDIC_GAIN_INV;
            y_reg[0] <= '0;
            z_reg[0] <= in_angle;
        end
    end

    // micro-rotation stages
    for (genvar i = 0; i < CORDIC_ITERS; i++)
    begin : g_iter
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (en)
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - atan_entry(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + atan_entry(i);
                end
            end
        end
    end

    // clamp to +-1.0 and round q32 to q30
    always_comb
    begin
        xc = x_reg[CORDIC_ITERS];
        yc = y_reg[CORDIC_ITERS];
        if (xc > ONE_Q32)
            xc = ONE_Q32;
        else if (xc < -ONE_Q32)
            xc = -ONE_Q32;
        if (yc > ONE_Q32)
            yc = ONE_Q32;
        else if (yc < -ONE_Q32)
            yc = -ONE_Q32;
        xc = (xc + CW'(2)) >>> 2;
        yc = (yc + CW'(2)) >>> 2;
        cos_next = xc[TW-1:0];
        sin_next = yc[TW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= v_reg[CORDIC_ITERS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign out_valid = vo_reg;
    assign out_cos   = cos_reg;
    assign out_sin   = sin_reg;

endmodule

>>> sv/e2q_combine.sv
// product formulas: pair product, rounding, third factor, sum, final round
module e2q_combine
    import e2q_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  e2q_trig_t in_trig,
    output logic      out_valid,
    output e2q_out_t  out_data
);

    localparam int SH = 60 - FRAC_BITS;
    localparam int PW = 2 * TW;
    localparam int QW = FRAC_BITS + 2;
    localparam logic signed [PW:0] ONE_Q = (PW+1)'(1) <<< FRAC_BITS;

    // term order: per output, two terms a*b*c
    logic signed [TW-1:0] ta [8];
    logic signed [TW-1:0] tb [8];
    logic signed [TW-1:0] tc [8];

    logic                 v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [PW-1:0] ab_reg [8];
    logic signed [TW-1:0] c1_reg [8];
    logic signed [TW-1:0] abr_reg [8];
    logic signed [TW-1:0] c2_reg [8];
    logic signed [PW-1:0] p_reg [8];
    logic signed [PW:0]   s_reg [4];
    logic signed [QW-1:0] q_reg [4];

    always_comb
    begin
        ta[0] = in_trig.sx; tb[0] = in_trig.cy; tc[0] = in_trig.cz;
        ta[1] = in_trig.cx; tb[1] = in_trig.sy; tc[1] = in_trig.sz;
        ta[2] = in_trig.cx; tb[2] = in_trig.sy; tc[2] = in_trig.cz;
        ta[3] = in_trig.sx; tb[3] = in_trig.cy; tc[3] = in_trig.sz;
        ta[4] = in_trig.cx; tb[4] = in_trig.cy; tc[4] = in_trig.sz;
        ta[5] = in_trig.sx; tb[5] = in_trig.sy; tc[5] = in_trig.cz;
        ta[6] = in_trig.cx; tb[6] = in_trig.cy; tc[6] = in_trig.cz;
        ta[7] = in_trig.sx; tb[7] = in_trig.sy; tc[7] = in_trig.sz;
    end

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    for (genvar k = 0; k < 8; k++)
    begin : g_term
        logic signed [PW-1:0] abr;
        assign abr = (ab_reg[k] + (PW'(1) <<< 29)) >>> 30;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                // first product
                ab_reg[k]  <= ta[k] * tb[k];
                c1_reg[k]  <= tc[k];
                // round to q30
                abr_reg[k] <= abr[TW-1:0];
                c2_reg[k]  <= c1_reg[k];
                // third factor, q60
                p_reg[k]   <= abr_reg[k] * c2_reg[k];
            end
        end
    end

    for (genvar j = 0; j < 4; j++)
    begin : g_out
        logic signed [PW:0] r;
        logic signed [QW-1:0] q;
        always_comb
        begin
            r = (s_reg[j] + ((PW+1)'(1) <<< (SH - 1))) >>> SH;
            if (r > ONE_Q)
                r = ONE_Q;
            else if (r < -ONE_Q)
                r = -ONE_Q;
            q = r[QW-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                // signs: x and z subtract, y and w add
                if (j == 0 || j == 2)
                    s_reg[j] <= {p_reg[2*j][PW-1], p_reg[2*j]}
                              - {p_reg[2*j+1][PW-1], p_reg[2*j+1]};
                else
                    s_reg[j] <= {p_reg[2*j][PW-1], p_reg[2*j]}
                              + {p_reg[2*j+1][PW-1], p_reg[2*j+1]};
                q_reg[j] <= q;
            end
        end
    end

    assign out_valid = v5_reg;
    assign out_data.quat_x = 16'(q_reg[0]);
    assign out_data.quat_y = 16'(q_reg[1]);
    assign out_data.quat_z = 16'(q_reg[2]);
    assign out_data.quat_w = 16'(q_reg[3]);

endmodule

>>> sv/euler_to_quaternion_unit.sv
// euler angles (x, y, z order) to unit quaternion
//
// input request: in_valid/in_ready with in_data carrying angle_x, angle_y,
// angle_z as signed binary angles, 2^ANGLE_BITS units per turn; z is negated.
// output request: out_valid/out_ready with out_data carrying quat_x..quat_w
// in signed q1.FRAC_BITS, saturated to +-1.0.
//
// pipeline from accept to out_valid: 1 load stage, 32 cordic stages,
// 1 trig round stage, 5 product/sum/round stages.
// throughput: one request per cycle while the output is not stalled, set
// by the fully unrolled cordic and the one-multiply-per-stage product chain.
//
// reset clears all valid bits; no clearing pass, the block is ready
// right after reset.
// stall: when out_valid is high and out_ready low the whole pipeline holds;
// in_ready follows, so nothing is lost or repeated. a bubble at the output
// lets the pipe advance under a stalled receiver.
module euler_to_quaternion_unit
    import e2q_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  e2q_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output e2q_out_t out_data
);

`include "assert_macros.svh"

    logic             en;
    logic             vx, vy, vz;
    logic             cv;
    e2q_trig_t        trig;
    logic signed [CW-1:0] hx, hy, hz;

    // pipeline advances unless a finished result is held
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // widen to 2^32 per turn, halve with floor
    function automatic logic signed [CW-1:0] half_ang(input logic [15:0] a);
        logic signed [31:0] w;
        logic [ANGLE_BITS-1:0] lo;
        lo = ANGLE_BITS'(a);
        w  = 32'(lo) << (32 - ANGLE_BITS);
        return CW'(w) >>> 1;
    endfunction

    assign hx = half_ang(in_data.angle_x);
    assign hy = half_ang(in_data.angle_y);
    assign hz = -half_ang(in_data.angle_z);

    e2q_cordic u_cx (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid && in_ready),
        .in_angle(hx), .out_valid(vx), .out_cos(trig.cx), .out_sin(trig.sx)
    );
    e2q_cordic u_cy (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid && in_ready),
        .in_angle(hy), .out_valid(vy), .out_cos(trig.cy), .out_sin(trig.sy)
    );
    e2q_cordic u_cz (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid && in_ready),
        .in_angle(hz), .out_valid(vz), .out_cos(trig.cz), .out_sin(trig.sz)
    );

    assign cv = vx;

    e2q_combine #(.FRAC_BITS(FRAC_BITS)) u_comb (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(cv),
        .in_trig(trig), .out_valid(out_valid), .out_data(out_data)
    );

    // the three cordic lanes stay in lockstep
    `ASSERT_CLK(a_lanes_aligned, clk, rst_n, (vx == vy) && (vy == vz), "cordic lanes out of step")
    // stalled result holds
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
    // ready only withheld while a result waits
    `ASSERT_CLK(a_ready_rule, clk, rst_n, in_ready || (out_valid && !out_ready), "input stalled without cause")

endmodule

>>> verif/testbench.sv
module testbench;
    import e2q_pkg::*;

    localparam int LATENCY   = 39;
    localparam int WATCHDOG  = 20000;
    localparam int N_RANDOM  = 1500;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    e2q_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    e2q_out_t out_data;

    euler_to_quaternion_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    e2q_in_t  pending_angles[$];
    e2q_out_t expected_quats[$];
    int       send_idle_pct;
    int       recv_stall_pct;
    int       long_hold;
    bit       drain_pause;
    int       n_errors;
    int       n_sent;
    int       n_received;
    int       quiet_cycles;

    longint atan_lut[32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };

    // arithmetic shift of a signed 64-bit value is a floor shift
    function automatic longint fdiv2(longint v, int s);
        return v >>> s;
    endfunction

    // 16-bit binary angle -> half angle in 2^32 units per turn
    function automatic longint half_turn(logic [15:0] raw);
        longint v;
        v = longint'($signed(raw)) <<< 16;
        return fdiv2(v, 1);
    endfunction

    function automatic longint clamp_one(longint v);
        if (v > 64'sd4294967296)
            return 64'sd4294967296;
        if (v < -64'sd4294967296)
            return -64'sd4294967296;
        return v;
    endfunction

    // rotation-mode cordic, cos and sin in q30
    function automatic void cos_sin(input longint ang, output longint c, output longint s);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = 64'sd2608131497;
        y = 0;
        z = ang;
        for (int i = 0; i < 32; i++)
        begin
            dx = fdiv2(y, i);
            dy = fdiv2(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_lut[i];
            end
            else
            begin
                x += dx; y -= dy; z += atan_lut[i];
            end
        end
        c = fdiv2(clamp_one(x) + 2, 2);
        s = fdiv2(clamp_one(y) + 2, 2);
    endfunction

    function automatic longint triple_q60(longint a, longint b, longint c);
        return fdiv2(a * b + (64'sd1 <<< 29), 30) * c;
    endfunction

    function automatic logic [15:0] round_sat(longint q);
        longint r;
        r = fdiv2(q + (64'sd1 <<< 45), 46);
        if (r > 16384)
            r = 16384;
        if (r < -16384)
            r = -16384;
        return r[15:0];
    endfunction

    function automatic e2q_out_t quat_of(e2q_in_t a);
        longint cx, sx, cy, sy, cz, sz;
        e2q_out_t q;
        cos_sin(half_turn(a.angle_x), cx, sx);
        cos_sin(half_turn(a.angle_y), cy, sy);
        cos_sin(-half_turn(a.angle_z), cz, sz);
        q.quat_x = round_sat(triple_q60(sx, cy, cz) - triple_q60(cx, sy, sz));
        q.quat_y = round_sat(triple_q60(cx, sy, cz) + triple_q60(sx, cy, sz));
        q.quat_z = round_sat(triple_q60(cx, cy, sz) - triple_q60(sx, sy, cz));
        q.quat_w = round_sat(triple_q60(cx, cy, cz) + triple_q60(sx, sy, sz));
        return q;
    endfunction

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(($urandom_range(0, 7)) * 16'h2000);
            3: return 16'($urandom_range(0, 8) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_quats.push_back(quat_of(in_data));
                n_sent++;
            end
            if (!(in_valid && !in_ready))
            begin
                if (pending_angles.size() > 0 && !drain_pause &&
                    $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_angles.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                n_received++;
                if (expected_quats.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, out_data);
                    n_errors++;
                end
                else
                begin
                    e2q_out_t q;
                    q = expected_quats.pop_front();
                    if (q.quat_x !== out_data.quat_x || q.quat_y !== out_data.quat_y ||
                        q.quat_z !== out_data.quat_z || q.quat_w !== out_data.quat_w)
                    begin
                        $display("%0t: expected x %0d y %0d z %0d w %0d, got x %0d y %0d z %0d w %0d",
                                 $time, q.quat_x, q.quat_y, q.quat_z, q.quat_w,
                                 out_data.quat_x, out_data.quat_y, out_data.quat_z,
                                 out_data.quat_w);
                        n_errors++;
                    end
                end
            end
            if (long_hold > 0)
            begin
                long_hold--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG)
        begin
            $display("watchdog expired");
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic push_triple(logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
        e2q_in_t a;
        a.angle_x = ax;
        a.angle_y = ay;
        a.angle_z = az;
        pending_angles.push_back(a);
    endtask

    task automatic wait_drained();
        while (pending_angles.size() > 0 || in_valid || expected_quats.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int phase_stall[4] = '{0, 0, 77, 16};
        int phase_idle[4]  = '{0, 77, 0, 16};
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_hold = 0;
        drain_pause = 0;
        n_errors = 0;
        n_sent = 0;
        n_received = 0;
        quiet_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, quarter turns, saturation corners, z negation
        push_triple(16'h0000, 16'h0000, 16'h0000);
        push_triple(16'h8000, 16'h8000, 16'h8000);
        push_triple(16'h7fff, 16'h7fff, 16'h7fff);
        push_triple(16'hffff, 16'h0001, 16'hffff);
        push_triple(16'h4000, 16'h0000, 16'h0000);
        push_triple(16'h0000, 16'h4000, 16'h0000);
        push_triple(16'h0000, 16'h0000, 16'h4000);
        push_triple(16'h0000, 16'h0000, 16'hc000);
        push_triple(16'hc000, 16'hc000, 16'hc000);
        push_triple(16'h8000, 16'h0000, 16'h0000);
        push_triple(16'h0000, 16'h8000, 16'h0000);
        push_triple(16'h0000, 16'h0000, 16'h8000);
        push_triple(16'h2000, 16'h2000, 16'h2000);
        push_triple(16'h5555, 16'haaaa, 16'h5555);
        push_triple(16'haaaa, 16'h5555, 16'haaaa);
        push_triple(16'h8000, 16'h7fff, 16'h8000);
        wait_drained();

        // random phases with different idle and stall mixes
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            for (int i = 0; i < N_RANDOM / 4; i++)
                push_triple(rand_angle(), rand_angle(), rand_angle());
            if (p == 0)
            begin
                // long receiver hold while the sender keeps offering
                long_hold = 200;
            end
            if (p == 2)
            begin
                // sender pauses mid-phase until all results are back
                while (pending_angles.size() > N_RANDOM / 8)
                    @(posedge clk);
                drain_pause = 1;
                while (in_valid || expected_quats.size() > 0)
                    @(posedge clk);
                drain_pause = 0;
            end
            wait_drained();
        end

        repeat (LATENCY + 10) @(posedge clk);
        $display("sent %0d angle triples, checked %0d quaternions, across 4 flow phases",
                 n_sent, n_received);
        $display("covered extreme angles, quarter turns and a long output stall");
        if (n_errors == 0 && expected_quats.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
